// ===== rtl/iil_pkg.sv =====
`default_nettype none
package iil_pkg;

  // Fixed field widths of the request and result words
  localparam int OP_W   = 4;
  localparam int POS_W  = 7;
  localparam int POS2_W = 6;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 7;

  // Operation codes; codes above OP_CLEAR are rejected
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 4'd0,
    OP_POP    = 4'd1,
    OP_GET    = 4'd2,
    OP_BACK   = 4'd3,
    OP_SET    = 4'd4,
    OP_INSERT = 4'd5,
    OP_REMOVE = 4'd6,
    OP_SWAP   = 4'd7,
    OP_CLEAR  = 4'd8
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/iil_in_if.sv =====
`default_nettype none
interface iil_in_if import iil_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [POS_W-1:0]  position;
  logic [POS2_W-1:0] other_position;
  logic [VAL_W-1:0]  value;

  modport source (output valid, output operation, output position,
                  output other_position, output value, input ready);
  modport sink   (input valid, input operation, input position,
                  input other_position, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/iil_out_if.sv =====
`default_nettype none
interface iil_out_if import iil_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [VAL_W-1:0] read_value;
  logic [CNT_W-1:0] count;

  modport source (output valid, output status, output read_value, output count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input count,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/iil_mem.sv =====
`default_nettype none
module iil_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data appears in the cycle after the address
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/indexed_insertable_list.sv =====
// Channel  | Dir | Handshake     | Word
// ---------+-----+---------------+----------------------------------------------
// in_ch    | in  | valid / ready | operation, position, other_position, value
// out_ch   | out | valid / ready | status, read_value, count
//
// Push, pop, set, clear, insert at the end and every rejected request finish
// straight from idle; get and back read the entry memory first; swap reads
// both entries, then writes both back; insert before the end and remove walk
// the entries behind the position through the single write port of the entry
// memory, which moves one entry per cycle. One request is worked on at a time.
// Reset (synchronous, active low) empties the list; entry contents are kept.
// A finished result parks in a holding register while out_ch stalls, and
// in_ch is ready again once that result has moved to the output register.
`default_nettype none
module indexed_insertable_list import iil_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  iil_in_if.sink    in_ch,
  iil_out_if.source out_ch
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_READ = 9'b000000010,
    S_INS  = 9'b000000100,
    S_INSV = 9'b000001000,
    S_REM  = 9'b000010000,
    S_SW1  = 9'b000100000,
    S_SW2  = 9'b001000000,
    S_SW3  = 9'b010000000,
    S_HOLD = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [IW-1:0]    k_r, k_nxt;
  logic [IW-1:0]    pos_r, pos2_r;
  logic [WIDTH-1:0] val_r, tmp_r, tmp_nxt;

  logic             out_valid_r;
  logic             out_status_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic [CNT_W-1:0] out_count_r;
  logic             pend_err_r;
  logic [VAL_W-1:0] pend_rd_r;

  // Memory port
  logic             mem_we;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  logic [WIDTH-1:0] mem_wdata, mem_rdata;

  // Width adaptation
  logic [CMPW-1:0]        pos_c, pos2_c, used_c, depth_c, used_nxt_c;
  logic [WIDTH+VAL_W-1:0] val_ext, rd_ext;
  logic [WIDTH-1:0]       val_w;
  logic [VAL_W-1:0]       rd32;

  logic fire, slot_free, fin, fin_err;
  logic [VAL_W-1:0] fin_rd;
  logic empty, full;
  op_t  op;

  assign pos_c      = CMPW'(in_ch.position);
  assign pos2_c     = CMPW'(in_ch.other_position);
  assign used_c     = CMPW'(used_r);
  assign depth_c    = CMPW'(DEPTH);
  assign used_nxt_c = CMPW'(used_nxt);
  assign val_ext    = {{WIDTH{1'b0}}, in_ch.value};
  assign val_w      = val_ext[WIDTH-1:0];
  assign rd_ext     = {{VAL_W{1'b0}}, mem_rdata};
  assign rd32       = rd_ext[VAL_W-1:0];

  assign empty     = (used_r == '0);
  assign full      = (used_c == depth_c);
  assign op        = op_t'(in_ch.operation);
  assign fire      = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  iil_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequence each request through the memory; the next request enters only
  // after the last write of this one, so no read can see a stale entry
  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    k_nxt     = k_r;
    tmp_nxt   = tmp_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = val_r;
    mem_raddr = '0;
    fin       = 1'b0;
    fin_err   = 1'b0;
    fin_rd    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          unique case (op)
            OP_PUSH: begin
              fin = 1'b1;
              if (full) begin
                fin_err = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = used_c[IW-1:0];
                mem_wdata = val_w;
                used_nxt  = used_r + 1'b1;
              end
            end
            OP_POP: begin
              fin = 1'b1;
              if (empty) begin
                fin_err = 1'b1;
              end else begin
                used_nxt = used_r - 1'b1;
              end
            end
            OP_GET: begin
              if (pos_c >= used_c) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else begin
                mem_raddr = pos_c[IW-1:0];
                state_nxt = S_READ;
              end
            end
            OP_BACK: begin
              if (empty) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else begin
                mem_raddr = used_c[IW-1:0] - 1'b1;
                state_nxt = S_READ;
              end
            end
            OP_SET: begin
              fin = 1'b1;
              if (pos_c >= used_c) begin
                fin_err = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_c[IW-1:0];
                mem_wdata = val_w;
              end
            end
            OP_INSERT: begin
              if ((pos_c > used_c) || full) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else if (pos_c == used_c) begin
                // insert at the end is a push
                fin       = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = used_c[IW-1:0];
                mem_wdata = val_w;
                used_nxt  = used_r + 1'b1;
              end else begin
                mem_raddr = used_c[IW-1:0] - 1'b1;
                k_nxt     = used_c[IW-1:0];
                state_nxt = S_INS;
              end
            end
            OP_REMOVE: begin
              if (pos_c >= used_c) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else if (pos_c == used_c - 1'b1) begin
                // removing the last entry moves nothing
                fin      = 1'b1;
                used_nxt = used_r - 1'b1;
              end else begin
                mem_raddr = pos_c[IW-1:0] + 1'b1;
                k_nxt     = pos_c[IW-1:0];
                state_nxt = S_REM;
              end
            end
            OP_SWAP: begin
              if ((pos_c >= used_c) || (pos2_c >= used_c)) begin
                fin     = 1'b1;
                fin_err = 1'b1;
              end else begin
                mem_raddr = pos_c[IW-1:0];
                state_nxt = S_SW1;
              end
            end
            OP_CLEAR: begin
              fin      = 1'b1;
              used_nxt = '0;
            end
            default: begin
              fin     = 1'b1;
              fin_err = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin    = 1'b1;
        fin_rd = rd32;
      end
      S_INS: begin
        // move entry k-1 up to k, fetch the one below
        mem_we    = 1'b1;
        mem_waddr = k_r;
        mem_wdata = mem_rdata;
        if (k_r - 1'b1 == pos_r) begin
          state_nxt = S_INSV;
        end else begin
          mem_raddr = k_r - 2'd2;
          k_nxt     = k_r - 1'b1;
        end
      end
      S_INSV: begin
        fin       = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
        used_nxt  = used_r + 1'b1;
      end
      S_REM: begin
        // move entry k+1 down to k, fetch the next one
        mem_we    = 1'b1;
        mem_waddr = k_r;
        mem_wdata = mem_rdata;
        if (CMPW'(k_r) + 2'd2 == used_c) begin
          fin      = 1'b1;
          used_nxt = used_r - 1'b1;
        end else begin
          mem_raddr = k_r + 2'd2;
          k_nxt     = k_r + 1'b1;
        end
      end
      S_SW1: begin
        tmp_nxt   = mem_rdata;
        mem_raddr = pos2_r;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = mem_rdata;
        state_nxt = S_SW3;
      end
      S_SW3: begin
        fin       = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = pos2_r;
        mem_wdata = tmp_r;
      end
      S_HOLD: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Finished work goes out directly or waits in the holding register
    if (fin) begin
      state_nxt = slot_free ? S_IDLE : S_HOLD;
    end
  end

  // Take no word while reset is held
  assign in_ch.ready = rst_n && (state_r == S_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (fin && slot_free) begin
        out_valid_r <= 1'b1;
      end else if ((state_r == S_HOLD) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request fields, walk index and result words
  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    tmp_r <= tmp_nxt;
    if (fire) begin
      pos_r  <= pos_c[IW-1:0];
      pos2_r <= pos2_c[IW-1:0];
      val_r  <= val_w;
    end
    if (fin && slot_free) begin
      out_status_r     <= fin_err;
      out_read_value_r <= fin_rd;
      out_count_r      <= used_nxt_c[CNT_W-1:0];
    end else if ((state_r == S_HOLD) && slot_free) begin
      out_status_r     <= pend_err_r;
      out_read_value_r <= pend_rd_r;
      out_count_r      <= used_c[CNT_W-1:0];
    end
    if (fin) begin
      pend_err_r <= fin_err;
      pend_rd_r  <= fin_rd;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_value = out_read_value_r;
  assign out_ch.count      = out_count_r;

endmodule
`default_nettype wire

// ===== bench/indexed_insertable_list_tb.sv =====
`default_nettype none
module indexed_insertable_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iil_pkg::*;

  localparam int unsigned LIST_DEPTH       = 64;
  localparam int unsigned RESET_CYCLES     = 5;
  localparam int unsigned PHASE_WORDS      = 600;
  localparam int unsigned HOLD_AFTER_WORDS = 100;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned END_SLACK        = 100;
  localparam int unsigned STALL_LIMIT      = 2000;
  localparam int unsigned MAX_REPORTS      = 10;

  // Codes past OP_CLEAR are rejected by the block
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  // Shapes of the random episodes
  localparam int unsigned MODE_FILL  = 0;
  localparam int unsigned MODE_DRAIN = 1;
  localparam int unsigned MODE_MIX   = 2;
  localparam int unsigned MODE_NOISE = 3;

  typedef struct packed {
    logic [OP_W-1:0]   op_code;
    logic [POS_W-1:0]  position;
    logic [POS2_W-1:0] other_position;
    logic [VAL_W-1:0]  value;
  } request_t;

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] count;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  iil_in_if  in_ch ();
  iil_out_if out_ch ();

  indexed_insertable_list #(
    .DEPTH(LIST_DEPTH),
    .WIDTH(VAL_W)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  request_t         pending_words[$];
  result_t          expected_results[$];
  logic [VAL_W-1:0] list_mem[LIST_DEPTH];
  int unsigned      list_used = 0;
  int unsigned      plan_count = 0;
  int unsigned      planned_words = 0;
  int unsigned      words_sent = 0;
  int unsigned      words_checked = 0;
  int unsigned      mismatches = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  bit               rx_hold = 1'b0;
  bit               in_word_taken = 1'b0;

  // Predict one result word and advance the list copy
  function automatic result_t list_model(request_t r);
    result_t res;
    logic [VAL_W-1:0] held;
    int unsigned k;
    res = '0;
    res.status = ST_OK;
    case (r.op_code)
      OP_PUSH: begin
        if (list_used >= LIST_DEPTH) begin
          res.status = ST_ERR;
        end else begin
          list_mem[list_used] = r.value;
          list_used++;
        end
      end
      OP_POP: begin
        if (list_used == 0) res.status = ST_ERR;
        else list_used--;
      end
      OP_GET: begin
        if (r.position >= list_used) res.status = ST_ERR;
        else res.read_value = list_mem[r.position];
      end
      OP_BACK: begin
        if (list_used == 0) res.status = ST_ERR;
        else res.read_value = list_mem[list_used - 1];
      end
      OP_SET: begin
        if (r.position >= list_used) res.status = ST_ERR;
        else list_mem[r.position] = r.value;
      end
      OP_INSERT: begin
        if (r.position > list_used || list_used >= LIST_DEPTH) begin
          res.status = ST_ERR;
        end else begin
          // shift the tail up by one
          for (k = list_used; k > r.position; k--) list_mem[k] = list_mem[k - 1];
          list_mem[r.position] = r.value;
          list_used++;
        end
      end
      OP_REMOVE: begin
        if (r.position >= list_used) begin
          res.status = ST_ERR;
        end else begin
          // close the gap
          for (k = r.position; k + 1 < list_used; k++) list_mem[k] = list_mem[k + 1];
          list_used--;
        end
      end
      OP_SWAP: begin
        if (r.position >= list_used || r.other_position >= list_used) begin
          res.status = ST_ERR;
        end else begin
          held = list_mem[r.position];
          list_mem[r.position] = list_mem[r.other_position];
          list_mem[r.other_position] = held;
        end
      end
      OP_CLEAR: list_used = 0;
      default: res.status = ST_ERR;
    endcase
    res.count = list_used[CNT_W-1:0];
    return res;
  endfunction

  // Track only the count while planning, to steer the sequences
  function automatic int unsigned count_after(request_t r, int unsigned c);
    case (r.op_code)
      OP_PUSH:   return (c < LIST_DEPTH) ? c + 1 : c;
      OP_POP:    return (c != 0) ? c - 1 : c;
      OP_INSERT: return (c < LIST_DEPTH && r.position <= c) ? c + 1 : c;
      OP_REMOVE: return (r.position < c) ? c - 1 : c;
      OP_CLEAR:  return 0;
      default:   return c;
    endcase
  endfunction

  task automatic queue_req(input logic [OP_W-1:0] op, input int unsigned pos,
                           input int unsigned pos2, input logic [VAL_W-1:0] val);
    request_t r;
    r = '{op, pos[POS_W-1:0], pos2[POS2_W-1:0], val};
    pending_words = {pending_words, r};
    plan_count = count_after(r, plan_count);
    planned_words++;
  endtask

  function automatic logic [VAL_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a legal index, sometimes the end or anywhere in range
  function automatic int unsigned pick_pos(int unsigned c, bit end_ok);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return $urandom_range(LIST_DEPTH);
    if (roll < 16) return c;
    if (roll < 22) return 0;
    if (c == 0) return end_ok ? 0 : $urandom_range(LIST_DEPTH);
    return $urandom_range(end_ok ? c : c - 1);
  endfunction

  function automatic int unsigned pick_other(int unsigned c);
    if ($urandom_range(9) == 0 || c == 0) return $urandom_range(LIST_DEPTH - 1);
    return $urandom_range(c - 1);
  endfunction

  task automatic plan_directed();
    // empty list: every read and shrink fails
    queue_req(OP_POP, 0, 0, 0);
    queue_req(OP_BACK, 0, 0, 0);
    queue_req(OP_GET, 0, 0, 0);
    queue_req(OP_REMOVE, 0, 0, 0);
    queue_req(OP_SWAP, 0, 0, 0);
    queue_req(OP_INSERT, 1, 0, 32'h1111_1111);
    // grow by push, insert at the end and insert at the front
    queue_req(OP_PUSH, 0, 0, 32'h0000_0000);
    queue_req(OP_PUSH, 0, 0, 32'hFFFF_FFFF);
    queue_req(OP_INSERT, 2, 0, 32'hA5A5_A5A5);
    queue_req(OP_INSERT, 0, 0, 32'h1234_5678);
    queue_req(OP_GET, 0, 0, 0);
    queue_req(OP_GET, 3, 0, 0);
    queue_req(OP_GET, LIST_DEPTH, 0, 0);
    queue_req(OP_BACK, 0, 0, 0);
    queue_req(OP_SET, 1, 0, 32'h5A5A_5A5A);
    queue_req(OP_SET, 4, 0, 32'hDEAD_BEEF);
    queue_req(OP_SWAP, 0, 3, 0);
    queue_req(OP_SWAP, 2, 2, 0);
    queue_req(OP_SWAP, 1, LIST_DEPTH - 1, 0);
    queue_req(OP_REMOVE, 0, 0, 0);
    queue_req(OP_REMOVE, 2, 0, 0);
    queue_req(OP_REMOVE, 2, 0, 0);
    queue_req(OP_UNUSED_LO, 0, 0, 32'hFFFF_FFFF);
    queue_req(OP_UNUSED_HI, LIST_DEPTH, LIST_DEPTH - 1, 32'hFFFF_FFFF);
    queue_req(OP_CLEAR, 0, 0, 0);
    queue_req(OP_BACK, 0, 0, 0);
  endtask

  task automatic plan_episode(int unsigned mode);
    int unsigned roll;
    int unsigned pos;
    logic [OP_W-1:0] op;
    case (mode)
      MODE_FILL: begin
        // grow to full, then knock on the full list
        while (plan_count < LIST_DEPTH) begin
          roll = $urandom_range(9);
          if (roll == 0) queue_req(OP_GET, pick_pos(plan_count, 0), 0, 0);
          else if (roll < 6) queue_req(OP_PUSH, $urandom_range(LIST_DEPTH), 0, rand_word());
          else queue_req(OP_INSERT, $urandom_range(plan_count), 0, rand_word());
        end
        repeat ($urandom_range(3, 1)) begin
          if ($urandom_range(1)) queue_req(OP_PUSH, 0, 0, rand_word());
          else queue_req(OP_INSERT, pick_pos(plan_count, 1), 0, rand_word());
        end
      end
      MODE_DRAIN: begin
        // shrink to empty, then knock on the empty list
        while (plan_count != 0) begin
          roll = $urandom_range(9);
          if (roll == 0) queue_req(OP_SWAP, pick_pos(plan_count, 0), pick_other(plan_count), 0);
          else if (roll < 5) queue_req(OP_POP, 0, 0, 0);
          else queue_req(OP_REMOVE, $urandom_range(plan_count - 1), 0, 0);
        end
        repeat ($urandom_range(3, 1)) begin
          case ($urandom_range(3))
            0: queue_req(OP_POP, 0, 0, 0);
            1: queue_req(OP_BACK, 0, 0, 0);
            2: queue_req(OP_REMOVE, pick_pos(plan_count, 0), 0, 0);
            default: queue_req(OP_GET, pick_pos(plan_count, 0), 0, 0);
          endcase
        end
      end
      MODE_MIX: begin
        repeat ($urandom_range(60, 10)) begin
          op = OP_W'($urandom_range(OP_CLEAR));
          if (op == OP_CLEAR && $urandom_range(4) != 0) op = OP_GET;
          pos = pick_pos(plan_count, op == OP_INSERT);
          if (op == OP_SWAP && $urandom_range(9) == 0) queue_req(op, pos, pos, 0);
          else queue_req(op, pos, pick_other(plan_count), rand_word());
        end
      end
      default: begin
        repeat ($urandom_range(12, 3)) begin
          queue_req(OP_W'($urandom_range(OP_UNUSED_HI)), $urandom_range(LIST_DEPTH),
                    $urandom_range(LIST_DEPTH - 1), rand_word());
        end
      end
    endcase
  endtask

  task automatic plan_random(int unsigned words, bit fill_first);
    int unsigned target;
    int unsigned roll;
    target = planned_words + words;
    if (fill_first) plan_episode(MODE_FILL);
    while (planned_words < target) begin
      roll = $urandom_range(9);
      if (roll < 2) plan_episode(MODE_FILL);
      else if (roll < 4) plan_episode(MODE_DRAIN);
      else if (roll < 9) plan_episode(MODE_MIX);
      else plan_episode(MODE_NOISE);
    end
  endtask

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic check_word(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result word: status %0d read_value %h count %0d",
                              got.status, got.read_value, got.count));
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status || got.read_value !== want.read_value ||
        got.count !== want.count) begin
      flag_mismatch($sformatf(
        {"result word %0d: expected status %0d read_value %h count %0d, ",
         "got status %0d read_value %h count %0d"},
        words_checked, want.status, want.read_value, want.count,
        got.status, got.read_value, got.count));
    end
    words_checked++;
  endtask

  // Offer the next request word; hold it until taken
  always @(negedge clk) begin : driver
    request_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_word_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = pending_words.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= nxt.op_code;
        in_ch.position       <= nxt.position;
        in_ch.other_position <= nxt.other_position;
        in_ch.value          <= nxt.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Drive result ready; drop it during the long hold-off
  always @(negedge clk) begin
    if (!rst_n || rx_hold) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin : monitor
    result_t got;
    result_t predicted;
    if (!rst_n) begin
      in_word_taken <= 1'b0;
    end else begin
      in_word_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predicted = list_model(request_t'{in_ch.operation, in_ch.position,
                                          in_ch.other_position, in_ch.value});
        expected_results = {expected_results, predicted};
        words_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.read_value, out_ch.count};
        check_word(got);
      end
    end
  end

  // Stall the result side for a long stretch so the input backs up
  initial begin : rx_hold_off
    wait (words_sent >= HOLD_AFTER_WORDS);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Abort when neither channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = '0;
    in_ch.position       = '0;
    in_ch.other_position = '0;
    in_ch.value          = '0;
    out_ch.ready         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // receiver-heavy idling, then sender-heavy, then none
    for (phase = 0; phase < 3; phase++) begin
      @(posedge clk);
      case (phase)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct = 45;
        end
        1: begin
          tx_idle_pct = 45;
          rx_idle_pct = 21;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (phase == 0) plan_directed();
      plan_random(PHASE_WORDS, phase == 0);
      while (pending_words.size() != 0) @(posedge clk);
    end

    while (in_ch.valid || expected_results.size() != 0) @(negedge clk);
    repeat (END_SLACK) @(posedge clk);
    if (expected_results.size() != 0) begin
      flag_mismatch($sformatf("%0d result words never arrived", expected_results.size()));
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
